/* sv/rotor_substitution_with_reflector_top_defines.svh */
// Assertion macros used by the checker file
`ifndef ROTOR_SUBSTITUTION_WITH_REFLECTOR_TOP_DEFINES_SVH
`define ROTOR_SUBSTITUTION_WITH_REFLECTOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/rsr_pkg.sv */
package rsr_pkg;

  localparam int SYM_W = 8;
  localparam int BIT_CNT_W = 3;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_FWD    = 2'd2,
    KIND_REV    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_REJECT     = 2'd1,
    STAT_NOT_LOADED = 2'd2,
    STAT_FULL       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_SEARCH,
    S_READ,
    S_CHECK,
    S_DECIDE,
    S_COPY,
    S_PAIR_I,
    S_PAIR_S,
    S_PAIR_W,
    S_FINISH,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_ij;
    logic inc_i;
    logic inc_j;
    logic clr_j;
    logic who_to_i;
    logic do_load;
    logic commit_start;
    logic chk_step;
    logic commit_end;
    logic mod_clr;
    logic mod_step;
    logic copy_wr;
    logic pair_self;
    logic pair_hit;
    logic pair_mate;
    logic res_notld;
    logic res_sym;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  n_zero;
    logic  loaded;
    logic  refl;
    logic  j_at_n;
    logic  i_at_n;
    logic  i_last;
    logic  j_last;
    logic  hit_fwd;
    logic  hit_rev;
    logic  hit_pair;
    logic  taken_i;
    logic  taken_j;
    logic  mod_done;
    logic  ok;
  } stat_t;

endpackage

/* sv/rsr_ctrl.sv */
module rsr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_valid,
  output logic           s_ready,
  output logic           m_valid,
  input  logic           m_ready,
  input  rsr_pkg::stat_t st,
  output rsr_pkg::cmd_t  cmd
);

  rsr_pkg::state_t state, state_next;
  logic hit;

  assign hit     = (st.kind == rsr_pkg::KIND_FWD) ? st.hit_fwd : st.hit_rev;
  assign s_ready = (state == rsr_pkg::S_IDLE);

  // state register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rsr_pkg::S_IDLE;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rsr_pkg::S_IDLE: begin
        if (s_valid) state_next = rsr_pkg::S_DISPATCH;
      end
      rsr_pkg::S_DISPATCH: begin
        case (st.kind)
          rsr_pkg::KIND_LOAD: state_next = rsr_pkg::S_EMIT;
          rsr_pkg::KIND_COMMIT:
            state_next = st.n_zero ? rsr_pkg::S_FINISH : rsr_pkg::S_CHECK;
          default: begin
            if (!st.loaded)   state_next = rsr_pkg::S_EMIT;
            else if (st.refl) state_next = rsr_pkg::S_SEARCH;
            else              state_next = rsr_pkg::S_MOD;
          end
        endcase
      end
      rsr_pkg::S_MOD: begin
        if (st.mod_done) state_next = rsr_pkg::S_SEARCH;
      end
      rsr_pkg::S_SEARCH: begin
        if (st.j_at_n || hit) state_next = rsr_pkg::S_READ;
      end
      rsr_pkg::S_READ: state_next = rsr_pkg::S_EMIT;
      rsr_pkg::S_CHECK: begin
        if (st.j_last && st.i_last) state_next = rsr_pkg::S_DECIDE;
      end
      rsr_pkg::S_DECIDE: begin
        if (!st.ok)       state_next = rsr_pkg::S_FINISH;
        else if (st.refl) state_next = rsr_pkg::S_PAIR_I;
        else              state_next = rsr_pkg::S_COPY;
      end
      rsr_pkg::S_COPY: begin
        if (st.i_at_n) state_next = rsr_pkg::S_FINISH;
      end
      rsr_pkg::S_PAIR_I: begin
        if (st.i_at_n)       state_next = rsr_pkg::S_FINISH;
        else if (!st.taken_i) state_next = rsr_pkg::S_PAIR_S;
      end
      rsr_pkg::S_PAIR_S: begin
        if (st.j_at_n) begin
          state_next = rsr_pkg::S_PAIR_I;
        end else if (st.hit_pair) begin
          state_next = st.taken_j ? rsr_pkg::S_PAIR_I : rsr_pkg::S_PAIR_W;
        end
      end
      rsr_pkg::S_PAIR_W: state_next = rsr_pkg::S_PAIR_I;
      rsr_pkg::S_FINISH: state_next = rsr_pkg::S_EMIT;
      rsr_pkg::S_EMIT: begin
        if (!m_valid || m_ready) state_next = rsr_pkg::S_IDLE;
      end
      default: state_next = rsr_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      rsr_pkg::S_IDLE: cmd.clr_ij = 1'b1;
      rsr_pkg::S_DISPATCH: begin
        case (st.kind)
          rsr_pkg::KIND_LOAD:   cmd.do_load = 1'b1;
          rsr_pkg::KIND_COMMIT: cmd.commit_start = 1'b1;
          default: begin
            if (!st.loaded) cmd.res_notld = 1'b1;
            else            cmd.mod_clr = 1'b1;
          end
        endcase
      end
      rsr_pkg::S_MOD: cmd.mod_step = 1'b1;
      rsr_pkg::S_SEARCH: begin
        if (st.j_at_n || hit) cmd.who_to_i = 1'b1;
        else                  cmd.inc_j = 1'b1;
      end
      rsr_pkg::S_READ: cmd.res_sym = 1'b1;
      rsr_pkg::S_CHECK: begin
        cmd.chk_step = 1'b1;
        if (st.j_last) begin
          if (st.i_last) begin
            cmd.clr_ij = 1'b1;
          end else begin
            cmd.inc_i = 1'b1;
            cmd.clr_j = 1'b1;
          end
        end else begin
          cmd.inc_j = 1'b1;
        end
      end
      rsr_pkg::S_COPY: begin
        if (!st.i_at_n) begin
          cmd.copy_wr = 1'b1;
          cmd.inc_i   = 1'b1;
        end
      end
      rsr_pkg::S_PAIR_I: begin
        if (!st.i_at_n) begin
          if (st.taken_i) begin
            cmd.inc_i = 1'b1;
          end else begin
            cmd.pair_self = 1'b1;
            cmd.clr_j     = 1'b1;
          end
        end
      end
      rsr_pkg::S_PAIR_S: begin
        if (st.j_at_n) begin
          cmd.inc_i = 1'b1;
        end else if (st.hit_pair) begin
          if (st.taken_j) cmd.inc_i = 1'b1;
          else            cmd.pair_hit = 1'b1;
        end else begin
          cmd.inc_j = 1'b1;
        end
      end
      rsr_pkg::S_PAIR_W: begin
        cmd.pair_mate = 1'b1;
        cmd.inc_i     = 1'b1;
      end
      rsr_pkg::S_FINISH: cmd.commit_end = 1'b1;
      rsr_pkg::S_EMIT: begin
        if (!m_valid || m_ready) cmd.emit = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

/* sv/rsr_datapath.sv */
module rsr_datapath #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  rsr_pkg::kind_t            kind,
  input  logic [rsr_pkg::SYM_W-1:0] symbol,
  input  logic [rsr_pkg::SYM_W-1:0] pair_symbol,
  input  logic [rsr_pkg::SYM_W-1:0] offset,
  input  logic                      inverter,
  input  rsr_pkg::cmd_t             cmd,
  output rsr_pkg::stat_t            st,
  output logic [rsr_pkg::SYM_W-1:0] symbol_out,
  output rsr_pkg::status_t          status
);

  localparam int CW = $clog2(MAX_SYMBOLS + 1);
  localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int MW = 2 * CW;
  localparam int SW = rsr_pkg::SYM_W;

  // captured request
  rsr_pkg::kind_t kind_q;
  logic [SW-1:0]  sym_q, pair_q, off_q;
  logic           inv_q;

  // rotor state
  logic [CW-1:0] cnt, rsize;
  logic          refl, loaded;

  // tables
  logic [SW-1:0] alph [MAX_SYMBOLS];
  logic [SW-1:0] raw  [MAX_SYMBOLS];
  logic [SW-1:0] wir  [MAX_SYMBOLS];
  logic [SW-1:0] ai_rd, aj_rd, ri_rd, rj_rd, wi_rd, wj_rd;

  // walk counters and work registers
  logic [CW-1:0] i, j, i_next, j_next, n, who, kq;
  logic [CW:0]   t_who, t_mod;
  logic [SW-1:0] cur_a, cur_r;
  logic [MAX_SYMBOLS-1:0] taken;
  logic          fail, full, ok;
  logic [MW-1:0] match_cnt;
  logic [CW-1:0] rem;
  logic [rsr_pkg::BIT_CNT_W-1:0] bcnt;
  logic [SW-1:0] res_sym;
  rsr_pkg::status_t res_st;
  logic          wr_w;
  logic [AW-1:0] wr_w_addr;
  logic [SW-1:0] wr_w_data;

  assign n    = (kind_q == rsr_pkg::KIND_COMMIT) ? cnt : rsize;
  assign full = (cnt == CW'(MAX_SYMBOLS));
  assign ok   = !fail && (match_cnt == MW'(n)) && (n != '0);

  // counter next values; table reads follow them so data lines up with i and j
  always_comb begin
    i_next = i;
    if (cmd.clr_ij)        i_next = '0;
    else if (cmd.inc_i)    i_next = i + CW'(1);
    else if (cmd.who_to_i) i_next = who;
    j_next = j;
    if (cmd.clr_ij || cmd.clr_j) j_next = '0;
    else if (cmd.inc_j)          j_next = j + CW'(1);
  end

  // position after the offset; an unfound symbol counts as index zero
  always_comb begin
    kq = st.j_at_n ? '0 : j;
    if (kind_q == rsr_pkg::KIND_FWD) begin
      t_who = {1'b0, kq} + {1'b0, rem};
    end else begin
      t_who = {1'b0, kq} + {1'b0, n} - {1'b0, rem};
    end
    if (t_who >= {1'b0, n}) t_who = t_who - {1'b0, n};
    who = t_who[CW-1:0];
  end

  // one restoring remainder step
  assign t_mod = {rem, off_q[bcnt]};

  // wiring table write port
  always_comb begin
    wr_w      = cmd.copy_wr | cmd.pair_self | cmd.pair_hit | cmd.pair_mate;
    wr_w_addr = cmd.pair_mate ? j[AW-1:0] : i[AW-1:0];
    if (cmd.copy_wr)        wr_w_data = ri_rd;
    else if (cmd.pair_self) wr_w_data = ai_rd;
    else if (cmd.pair_hit)  wr_w_data = cur_r;
    else                    wr_w_data = cur_a;
  end

  // tables
  always_ff @(posedge clk) begin
    if (cmd.do_load && !full) begin
      alph[cnt[AW-1:0]] <= sym_q;
      raw[cnt[AW-1:0]]  <= pair_q;
    end
    if (wr_w) wir[wr_w_addr] <= wr_w_data;
    ai_rd <= alph[i_next[AW-1:0]];
    aj_rd <= alph[j_next[AW-1:0]];
    ri_rd <= raw[i_next[AW-1:0]];
    rj_rd <= raw[j_next[AW-1:0]];
    wi_rd <= wir[i_next[AW-1:0]];
    wj_rd <= wir[j_next[AW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rsize  <= '0;
      refl   <= 1'b0;
      loaded <= 1'b0;
      i      <= '0;
      j      <= '0;
    end else begin
      i <= i_next;
      j <= j_next;
      if (cmd.do_load && !full) begin
        cnt <= cnt + CW'(1);
        if (cnt == '0) loaded <= 1'b0;
      end
      if (cmd.commit_start) refl <= inv_q;
      if (cmd.commit_end) begin
        rsize  <= ok ? cnt : '0;
        loaded <= ok;
        cnt    <= '0;
      end
    end
  end

  // request capture, commit work and result
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind;
      sym_q  <= symbol;
      pair_q <= pair_symbol;
      off_q  <= offset;
      inv_q  <= inverter;
    end
    if (cmd.commit_start) begin
      fail      <= 1'b0;
      match_cnt <= '0;
      taken     <= '0;
    end
    if (cmd.chk_step) begin
      if (j == '0 && (ai_rd == '0 || ri_rd == '0 || (refl && ai_rd == ri_rd))) begin
        fail <= 1'b1;
      end
      if (rj_rd == ai_rd) match_cnt <= match_cnt + MW'(1);
    end
    if (cmd.pair_self) begin
      cur_a <= ai_rd;
      cur_r <= ri_rd;
    end
    if (cmd.pair_hit)  taken[i[AW-1:0]] <= 1'b1;
    if (cmd.pair_mate) taken[j[AW-1:0]] <= 1'b1;
    if (cmd.mod_clr) begin
      rem  <= '0;
      bcnt <= rsr_pkg::BIT_CNT_W'(SW - 1);
    end
    if (cmd.mod_step) begin
      rem  <= (t_mod >= {1'b0, n}) ? CW'(t_mod - {1'b0, n}) : t_mod[CW-1:0];
      bcnt <= bcnt - rsr_pkg::BIT_CNT_W'(1);
    end
    if (cmd.do_load) begin
      res_sym <= '0;
      res_st  <= full ? rsr_pkg::STAT_FULL : rsr_pkg::STAT_OK;
    end
    if (cmd.commit_end) begin
      res_sym <= '0;
      res_st  <= ok ? rsr_pkg::STAT_OK : rsr_pkg::STAT_REJECT;
    end
    if (cmd.res_notld) begin
      res_sym <= '0;
      res_st  <= rsr_pkg::STAT_NOT_LOADED;
    end
    if (cmd.res_sym) begin
      res_sym <= (kind_q == rsr_pkg::KIND_FWD) ? wi_rd : ai_rd;
      res_st  <= rsr_pkg::STAT_OK;
    end
    if (cmd.emit) begin
      symbol_out <= res_sym;
      status     <= res_st;
    end
  end

  // status to the controller
  always_comb begin
    st.kind     = kind_q;
    st.n_zero   = (n == '0);
    st.loaded   = loaded;
    st.refl     = refl;
    st.j_at_n   = (j == n);
    st.i_at_n   = (i == n);
    st.i_last   = ((i + CW'(1)) == n);
    st.j_last   = ((j + CW'(1)) == n);
    st.hit_fwd  = (aj_rd == sym_q);
    st.hit_rev  = (wj_rd == sym_q);
    st.hit_pair = (aj_rd == cur_r);
    st.taken_i  = taken[i[AW-1:0]];
    st.taken_j  = taken[j[AW-1:0]];
    st.mod_done = (bcnt == '0);
    st.ok       = ok;
  end

endmodule

/* sv/rotor_substitution_with_reflector_top.sv */
// Single cipher rotor with optional reflector pairing.
// Input stream: s_tuser carries the request kind (load pair, commit, forward,
// reverse); s_tdata carries symbol, pair symbol, offset and inverter flag.
// Output stream: one response per request, symbol_out and status in m_tdata.
// One request is worked at a time; s_tready is high only while idle.
// Request steps, n = committed or staged count: a load or a not-loaded encipher
//   answers directly; forward/reverse reduce the offset modulo n (not for a
//   reflector), then search the table one entry per cycle; a commit matches
//   every pair of entries, then, if the check passes, copies the wiring, or for
//   a reflector pairs entries (each free entry searches the alphabet)
// Responses wait in an output register; a stalled m_tready holds the block in
// its final step until the register drains, while the request itself is
// already done. Reset clears the counters, the loaded flag and the output
// valid; the tables need no clearing since they are read only after writes.
module rotor_substitution_with_reflector_top #(
  parameter int MAX_SYMBOLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // symbol[7:0], pair_symbol[15:8], offset[23:16], inverter[24]
  input  logic [1:0]  s_tuser,  // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // symbol_out[7:0], status[9:8]
);

  rsr_pkg::cmd_t    cmd;
  rsr_pkg::stat_t   st;
  rsr_pkg::status_t status;
  logic [rsr_pkg::SYM_W-1:0] symbol_out;

  rsr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .st      (st),
    .cmd     (cmd)
  );

  rsr_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .accept      (s_tvalid && s_tready),
    .kind        (rsr_pkg::kind_t'(s_tuser)),
    .symbol      (s_tdata[7:0]),
    .pair_symbol (s_tdata[15:8]),
    .offset      (s_tdata[23:16]),
    .inverter    (s_tdata[24]),
    .cmd         (cmd),
    .st          (st),
    .symbol_out  (symbol_out),
    .status      (status)
  );

  assign m_tdata = {6'b0, status, symbol_out};

endmodule

/* sv/rsr_checker.sv */
`include "rotor_substitution_with_reflector_top_defines.svh"

module rsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // stalled response holds
  `RSR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "response changed while stalled")

  // one request at a time
  `RSR_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "request taken while busy")

  // a response never shows up the cycle after a request on an empty output
  `RSR_ASSERT_NEXT(a_lat, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "response too early")

  // error responses carry no symbol, padding stays zero
  `RSR_ASSERT_SAME(a_err, m_tvalid && m_tdata[9:8] != 2'd0, m_tdata[7:0] == 8'd0, "symbol on error")
  `RSR_ASSERT_SAME(a_pad, m_tvalid, m_tdata[15:10] == 6'd0, "nonzero padding")

endmodule

bind rotor_substitution_with_reflector_top rsr_checker u_rsr_checker (.*);

/* sim/rotor_substitution_with_reflector_top_tb.sv */
module rotor_substitution_with_reflector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM = 64;
  localparam int STALL_LIMIT = 40000;
  localparam int RAND_ITEMS = 1500;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  rotor_substitution_with_reflector_top #(.MAX_SYMBOLS(NSYM)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  typedef struct packed {
    logic [7:0]       sym;
    rsr_pkg::status_t status;
  } cipher_resp_t;

  // rotor model state
  logic [7:0] alpha_tab [NSYM];
  logic [7:0] stage_wire [NSYM];
  logic [7:0] wire_tab [NSYM];
  int unsigned staged_n;
  int unsigned rotor_n;
  bit refl_mode;
  bit rotor_ready;

  cipher_resp_t resp_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle;

  // request currently on the bus, with an optional hand-typed response
  bit           cur_typed;
  cipher_resp_t cur_exp;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned find_sym(bit in_wire, int unsigned n, logic [7:0] s);
    for (int unsigned k = 0; k < n; k++) begin
      if ((in_wire ? wire_tab[k] : alpha_tab[k]) == s) return k;
    end
    return n;
  endfunction

  // validate staged wiring and build the committed table
  function automatic bit build_wiring(int unsigned n);
    bit taken [NSYM];
    int unsigned hits;
    int unsigned k;
    hits = 0;
    if (n == 0 || n > NSYM) return 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (alpha_tab[i] == 0 || stage_wire[i] == 0) return 0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned j = 0; j < n; j++) begin
        if (stage_wire[j] == alpha_tab[i]) hits++;
      end
      if (refl_mode && stage_wire[i] == alpha_tab[i]) return 0;
    end
    if (hits != n) return 0;
    if (!refl_mode) begin
      for (int unsigned i = 0; i < n; i++) wire_tab[i] = stage_wire[i];
      return 1;
    end
    for (int unsigned i = 0; i < NSYM; i++) taken[i] = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (taken[i]) continue;
      k = n;
      for (int unsigned q = 0; q < n; q++) begin
        if (alpha_tab[q] == stage_wire[i]) begin
          k = q;
          break;
        end
      end
      if (k >= n || taken[k]) continue;
      wire_tab[i] = stage_wire[i];
      taken[i] = 1;
      for (int unsigned j = 0; j < n; j++) begin
        if (alpha_tab[j] != wire_tab[i] || taken[j]) continue;
        wire_tab[j] = alpha_tab[i];
        taken[j] = 1;
        break;
      end
    end
    for (int unsigned i = 0; i < n; i++) begin
      if (!taken[i]) wire_tab[i] = alpha_tab[i];
    end
    return 1;
  endfunction

  // advance the rotor model by one request
  function automatic cipher_resp_t rotor_predict(rsr_pkg::kind_t kd, logic [7:0] s,
                                                 logic [7:0] p, logic [7:0] off, logic inv);
    cipher_resp_t r;
    int unsigned sh;
    int unsigned idx;
    r.sym = 8'd0;
    r.status = rsr_pkg::STAT_OK;
    case (kd)
      rsr_pkg::KIND_LOAD: begin
        if (staged_n >= NSYM) begin
          r.status = rsr_pkg::STAT_FULL;
        end else begin
          if (staged_n == 0) rotor_ready = 0;
          alpha_tab[staged_n] = s;
          stage_wire[staged_n] = p;
          staged_n++;
        end
      end
      rsr_pkg::KIND_COMMIT: begin
        refl_mode = inv;
        if (build_wiring(staged_n)) begin
          rotor_n = staged_n;
          rotor_ready = 1;
        end else begin
          rotor_n = 0;
          rotor_ready = 0;
          r.status = rsr_pkg::STAT_REJECT;
        end
        staged_n = 0;
      end
      default: begin
        if (!rotor_ready || rotor_n == 0) begin
          r.status = rsr_pkg::STAT_NOT_LOADED;
        end else begin
          sh = refl_mode ? 0 : off % rotor_n;
          if (kd == rsr_pkg::KIND_FWD) begin
            idx = (find_sym(1'b0, rotor_n, s) + sh) % rotor_n;
            r.sym = wire_tab[idx];
          end else begin
            idx = (find_sym(1'b1, rotor_n, s) + rotor_n - sh) % rotor_n;
            r.sym = alpha_tab[idx];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one request and hold it until accepted
  task automatic send_req(rsr_pkg::kind_t kd, logic [7:0] s, logic [7:0] p, logic [7:0] off,
                          logic inv, bit typed = 0, cipher_resp_t exp_r = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata   <= {7'd0, inv, off, p, s};
    s_tuser   <= kd;
    cur_typed <= typed;
    cur_exp   <= exp_r;
    s_tvalid  <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_wait();
    s_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  // output side: random back-pressure
  always @(negedge clk) begin
    int gap;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      gap = pick_gap();
      m_tready <= (gap == 0) ? 1'b1 : ($urandom_range(0, gap) == 0);
    end
  end

  // accept requests, predict, and check responses
  always @(posedge clk) begin
    cipher_resp_t pr;
    cipher_resp_t ex;
    if (!rst) begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        idle_cycles = 0;
        pr = rotor_predict(rsr_pkg::kind_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
                           s_tdata[23:16], s_tdata[24]);
        resp_q.push_back(cur_typed ? cur_exp : pr);
      end
      if (m_tvalid && m_tready) begin
        idle_cycles = 0;
        if (resp_q.size() == 0) begin
          $display("%0t: unexpected response sym=%h status=%0d", $time, m_tdata[7:0],
                   m_tdata[9:8]);
          errors++;
        end else begin
          ex = resp_q.pop_front();
          if (m_tdata[7:0] !== ex.sym) begin
            $display("%0t: symbol_out expected %h actual %h", $time, ex.sym, m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[9:8] !== ex.status) begin
            $display("%0t: status expected %0d actual %0d", $time, ex.status, m_tdata[9:8]);
            errors++;
          end
        end
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  typedef struct {
    rsr_pkg::kind_t   kd;
    logic [7:0]       s;
    logic [7:0]       p;
    logic [7:0]       off;
    logic             inv;
    bit               typed;
    logic [7:0]       esym;
    rsr_pkg::status_t est;
  } dir_row_t;

  // directed requests; typed rows give the response directly
  dir_row_t dir_tab [] = '{
    '{rsr_pkg::KIND_FWD,    8'h41, 8'h00, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_NOT_LOADED},
    '{rsr_pkg::KIND_REV,    8'hFF, 8'hFF, 8'hFF, 1'b1, 1, 8'h00, rsr_pkg::STAT_NOT_LOADED},
    '{rsr_pkg::KIND_COMMIT, 8'h00, 8'h00, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_REJECT},
    '{rsr_pkg::KIND_LOAD,   8'hFF, 8'h01, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_LOAD,   8'h01, 8'hFF, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_COMMIT, 8'h00, 8'h00, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_FWD,    8'hFF, 8'h00, 8'h00, 1'b0, 1, 8'h01, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_FWD,    8'hFF, 8'h00, 8'hFF, 1'b0, 1, 8'hFF, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_REV,    8'h01, 8'h00, 8'h00, 1'b0, 1, 8'hFF, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_FWD,    8'h77, 8'h00, 8'h03, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_REV,    8'h77, 8'h00, 8'h80, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    // zero symbol rejects the wiring
    '{rsr_pkg::KIND_LOAD,   8'h00, 8'h05, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_LOAD,   8'h05, 8'h00, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_COMMIT, 8'h00, 8'h00, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_REJECT},
    '{rsr_pkg::KIND_FWD,    8'h05, 8'h00, 8'h00, 1'b0, 1, 8'h00, rsr_pkg::STAT_NOT_LOADED},
    // reflector entry mapping to itself
    '{rsr_pkg::KIND_LOAD,   8'h10, 8'h10, 8'h00, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_COMMIT, 8'h00, 8'h00, 8'h00, 1'b1, 1, 8'h00, rsr_pkg::STAT_REJECT},
    // reflector with a wiring symbol outside the alphabet
    '{rsr_pkg::KIND_LOAD,   8'h01, 8'h09, 8'h00, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_LOAD,   8'h02, 8'h01, 8'h00, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_LOAD,   8'h01, 8'h02, 8'h00, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_COMMIT, 8'h00, 8'h00, 8'h00, 1'b1, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_FWD,    8'h01, 8'h00, 8'h55, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_FWD,    8'h02, 8'h00, 8'hAA, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK},
    '{rsr_pkg::KIND_REV,    8'h09, 8'h00, 8'h01, 1'b0, 0, 8'h00, rsr_pkg::STAT_OK}
  };

  // load a random rotor, commit it, then encipher through it
  task automatic rotor_session(int unsigned n, bit refl, bit full_test);
    logic [7:0] al [NSYM];
    logic [7:0] wr [NSYM];
    bit used [256];
    int unsigned j;
    int unsigned nenc;
    logic [7:0] t;
    for (int i = 0; i < 256; i++) used[i] = 0;
    for (int unsigned i = 0; i < n; i++) begin
      do t = 8'($urandom_range(1, 255)); while (used[t]);
      used[t] = 1;
      al[i] = t;
      wr[i] = t;
    end
    if (refl) begin
      // fixed-point-free pairing where possible
      for (int unsigned i = 0; i < n; i++) begin
        j = $urandom_range(i, n - 1);
        t = al[i]; al[i] = al[j]; al[j] = t;
      end
      for (int unsigned i = 0; i + 1 < n; i += 2) begin
        wr[i] = al[i + 1];
        wr[i + 1] = al[i];
      end
      if (n % 2) wr[n - 1] = al[n - 1];
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        j = $urandom_range(i, n - 1);
        t = wr[i]; wr[i] = wr[j]; wr[j] = t;
      end
    end
    // occasional corruption
    if ($urandom_range(0, 9) == 0) begin
      j = $urandom_range(0, n - 1);
      if ($urandom_range(0, 1)) wr[j] = 8'($urandom_range(0, 255));
      else al[j] = ($urandom_range(0, 3) == 0) ? 8'd0 : al[$urandom_range(0, n - 1)];
    end
    for (int unsigned i = 0; i < n; i++) begin
      send_req(rsr_pkg::KIND_LOAD, al[i], wr[i], 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    end
    if (full_test) begin
      send_req(rsr_pkg::KIND_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'd0, 1'b0, 1, '{sym: 8'd0, status: rsr_pkg::STAT_FULL});
    end
    send_req(rsr_pkg::KIND_COMMIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), refl);
    nenc = $urandom_range(3, 15);
    for (int unsigned i = 0; i < nenc; i++) begin
      t = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
          ($urandom_range(0, 1) ? al[$urandom_range(0, n - 1)] : wr[$urandom_range(0, n - 1)]);
      send_req($urandom_range(0, 1) ? rsr_pkg::KIND_FWD : rsr_pkg::KIND_REV, t,
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rsr_pkg::KIND_LOAD;
    cur_typed = 0;
    cur_exp = '0;
    no_idle = 0;
    staged_n = 0;
    rotor_n = 0;
    refl_mode = 0;
    rotor_ready = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].kd, dir_tab[i].s, dir_tab[i].p, dir_tab[i].off, dir_tab[i].inv,
               dir_tab[i].typed, '{sym: dir_tab[i].esym, status: dir_tab[i].est});
    end
    // full table, one overflow, largest rotor
    rotor_session(NSYM, 0, 1);
    drain_wait();
    rotor_session(NSYM, 1, 0);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        r = $urandom_range(0, 99);
        n = (r < 80) ? $urandom_range(1, 8) : (r < 97) ? $urandom_range(9, 20) : NSYM;
        rotor_session(n, 1'($urandom_range(0, 1)), 0);
        sent += n + 10;
      end else begin
        // loose noise requests
        repeat ($urandom_range(1, 6)) begin
          send_req(rsr_pkg::kind_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
          sent++;
        end
      end
      if ($urandom_range(0, 40) == 0) drain_wait();
    end

    s_tvalid <= 1'b0;
    while (resp_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/rsr_pkg.sv
sv/rsr_ctrl.sv
sv/rsr_datapath.sv
sv/rotor_substitution_with_reflector_top.sv
sv/rsr_checker.sv
sim/rotor_substitution_with_reflector_top_tb.sv
